### rtl/core/gftq_pkg.sv
// Package: shared constants, codes and control structs of the team queue.
`default_nettype none

package gftq_pkg;

  // Default sizes
  localparam int NUM_TEAMS_DEF   = 16;
  localparam int TEAM_DEPTH_DEF  = 16;
  localparam int ELEMENT_IDS_DEF = 1024;

  // Fixed field widths of the item channels
  localparam int ACTION_W  = 2;
  localparam int ELEMENT_W = 10;
  localparam int TEAM_W    = 4;
  localparam int STATUS_W  = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_MAP   = 2'd0,
    ACT_ENQ   = 2'd1,
    ACT_DEQ   = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_EMPTY    = 2'd1,
    STS_FULL     = 2'd2,
    STS_UNMAPPED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_MAP,
    S_ENQ_LOOK,
    S_ENQ_PUT,
    S_DEQ_RING,
    S_DEQ_META,
    S_DEQ_READ,
    S_CLEAR,
    S_HOLD
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    take;           // latch the accepted item
    logic    sweep;          // clearing pass step
    logic    sweep_init;     // pass after reset (member table too)
    logic    map_wr;         // write member table entry
    logic    team_load;      // register team number and store base
    logic    team_from_ring; // team comes from the active ring, else member table
    logic    enq_put;        // commit an enqueue
    logic    deq_take;       // commit a dequeue
    logic    finish;         // result is ready this cycle
    logic    res_take;       // result element comes from the team store
    status_t res_status;
    logic    flush;          // move the held result to the output
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic sweep_last;
    logic map_bad;
    logic unmapped;
    logic enq_full;
    logic ring_empty;
    logic team_empty;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

### rtl/core/gftq_if.sv
// Interfaces: input item channel and result item channel.
`default_nettype none

interface gftq_item_if;
  import gftq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [ELEMENT_W-1:0] element;
  logic [TEAM_W-1:0]    team;

  modport source (output valid, output action, output element, output team, input ready);
  modport sink   (input valid, input action, input element, input team, output ready);
endinterface

interface gftq_result_if;
  import gftq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ELEMENT_W-1:0] out_element;
  logic [STATUS_W-1:0]  status;

  modport source (output valid, output out_element, output status, input ready);
  modport sink   (input valid, input out_element, input status, output ready);
endinterface

`default_nettype wire

### rtl/core/gftq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gftq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/gftq_ctrl.sv
// Controller: sequences map, enqueue, dequeue, clear and the reset clearing pass.
`default_nettype none

module gftq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire gftq_pkg::action_t in_action,
  output logic                  in_ready,
  input  wire gftq_pkg::stat_t  stat,
  output gftq_pkg::cmd_t        cmd
);
  import gftq_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.res_status = STS_OK;
    case (state)
      S_INIT: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_init = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          case (in_action)
            ACT_MAP:   state_next = S_MAP;
            ACT_ENQ:   state_next = S_ENQ_LOOK;
            ACT_DEQ:   state_next = S_DEQ_RING;
            ACT_CLEAR: state_next = S_CLEAR;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_MAP: begin
        cmd.finish = 1'b1;
        if (stat.map_bad) begin
          cmd.res_status = STS_UNMAPPED;
        end else begin
          cmd.map_wr = 1'b1;
        end
      end
      S_ENQ_LOOK: begin
        if (stat.unmapped) begin
          cmd.finish     = 1'b1;
          cmd.res_status = STS_UNMAPPED;
        end else begin
          cmd.team_load = 1'b1;
          state_next    = S_ENQ_PUT;
        end
      end
      S_ENQ_PUT: begin
        cmd.finish = 1'b1;
        if (stat.enq_full) begin
          cmd.res_status = STS_FULL;
        end else begin
          cmd.enq_put = 1'b1;
        end
      end
      S_DEQ_RING: begin
        if (stat.ring_empty) begin
          cmd.finish     = 1'b1;
          cmd.res_status = STS_EMPTY;
        end else begin
          cmd.team_load      = 1'b1;
          cmd.team_from_ring = 1'b1;
          state_next         = S_DEQ_META;
        end
      end
      S_DEQ_META: begin
        if (stat.team_empty) begin
          cmd.finish     = 1'b1;
          cmd.res_status = STS_EMPTY;
        end else begin
          cmd.deq_take = 1'b1;
          state_next   = S_DEQ_READ;
        end
      end
      S_DEQ_READ: begin
        cmd.finish   = 1'b1;
        cmd.res_take = 1'b1;
      end
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          cmd.finish = 1'b1;
        end
      end
      S_HOLD: begin
        if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // A finished item returns to idle, or waits for the output slot
    if (cmd.finish) begin
      state_next = stat.out_free ? S_IDLE : S_HOLD;
    end
  end

  // A result that finds the output slot busy is held
  a_hold_when_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && !stat.out_free) |=> (state == S_HOLD))
    else $error("busy output did not hold result");

  // One item in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in flight");

  // Dequeue commit only follows a non-empty team check
  a_deq_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.deq_take |-> !stat.team_empty && (state == S_DEQ_META))
    else $error("dequeue committed on empty team");

endmodule

`default_nettype wire

### rtl/core/gftq_dpath.sv
// Datapath: member table, per-team rings, active ring and the result register.
`default_nettype none

module gftq_dpath #(
  parameter int NUM_TEAMS   = gftq_pkg::NUM_TEAMS_DEF,
  parameter int TEAM_DEPTH  = gftq_pkg::TEAM_DEPTH_DEF,
  parameter int ELEMENT_IDS = gftq_pkg::ELEMENT_IDS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [gftq_pkg::ELEMENT_W-1:0]   in_element,
  input  wire logic [gftq_pkg::TEAM_W-1:0]      in_team,
  input  wire gftq_pkg::cmd_t                   cmd,
  output gftq_pkg::stat_t                       stat,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [gftq_pkg::ELEMENT_W-1:0]        out_element,
  output logic [gftq_pkg::STATUS_W-1:0]         out_status
);
  import gftq_pkg::*;

  localparam int TW  = $clog2(NUM_TEAMS);
  localparam int HW  = $clog2(TEAM_DEPTH);
  localparam int CW  = $clog2(TEAM_DEPTH + 1);
  localparam int AW  = $clog2(NUM_TEAMS + 1);
  localparam int MW  = $clog2(ELEMENT_IDS);
  localparam int SD  = NUM_TEAMS * TEAM_DEPTH;
  localparam int SA  = $clog2(SD);
  localparam int SN  = (ELEMENT_IDS > NUM_TEAMS) ? ELEMENT_IDS : NUM_TEAMS;
  localparam int SWW = $clog2(SN);

  // Latched item
  logic [ELEMENT_W-1:0] item_el;
  logic [TEAM_W-1:0]    item_team;

  // Team under work and the base of its store slots
  logic [TW-1:0] team_r;
  logic [SA-1:0] base_r;

  // Active ring pointers
  logic [TW-1:0] active_head, active_tail;
  logic [AW-1:0] active_count;

  logic [SWW-1:0] sweep_idx;
  logic           init_pass;

  // Memory ports
  logic          mem_we;
  logic [MW-1:0] mem_waddr;
  logic [TW:0]   mem_wdata, mem_q;
  logic          meta_we;
  logic [TW-1:0] meta_waddr, meta_raddr;
  logic [HW+CW-1:0] meta_wdata, meta_q;
  logic          store_we;
  logic [SA-1:0] store_waddr, store_raddr;
  logic [ELEMENT_W-1:0] store_q;
  logic          ring_we;
  logic [TW-1:0] ring_q;

  logic [HW-1:0] meta_head, head_inc, tail;
  logic [CW-1:0] meta_count;
  logic [HW:0]   tail_sum;
  logic [TW-1:0] team_src;
  logic          team_empty, ring_full, sweep_last;
  logic [ELEMENT_W-1:0] res_el;
  logic [ELEMENT_W-1:0] pend_el;
  status_t       pend_st;

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_el   <= in_element;
      item_team <= in_team;
    end
  end

  // Clearing pass counter; the pass after reset also covers the member table
  assign sweep_last = init_pass ? (sweep_idx == SWW'(SN - 1))
                                : (sweep_idx == SWW'(NUM_TEAMS - 1));
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_idx <= '0;
      init_pass <= 1'b1;
    end else if (cmd.sweep) begin
      sweep_idx <= sweep_last ? '0 : sweep_idx + SWW'(1);
      if (sweep_last) begin
        init_pass <= 1'b0;
      end
    end
  end

  // Member table: {valid, team}
  assign mem_we    = (cmd.sweep_init && (32'(sweep_idx) < ELEMENT_IDS)) || cmd.map_wr;
  assign mem_waddr = cmd.map_wr ? MW'(item_el) : MW'(sweep_idx);
  assign mem_wdata = cmd.map_wr ? {1'b1, TW'(item_team)} : '0;

  gftq_ram #(.WIDTH(TW + 1), .DEPTH(ELEMENT_IDS)) u_member (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (MW'(in_element)),
    .rdata (mem_q)
  );

  // Team select and store base
  assign team_src = cmd.team_from_ring ? ring_q : mem_q[TW-1:0];
  always_ff @(posedge clk) begin
    if (cmd.team_load) begin
      team_r <= team_src;
      base_r <= SA'(int'(team_src) * TEAM_DEPTH);
    end
  end

  // Per-team metadata: {head, count}; tail is head + count
  assign meta_head  = meta_q[HW+CW-1:CW];
  assign meta_count = meta_q[CW-1:0];
  assign team_empty = (meta_count == '0);
  assign head_inc   = (meta_head == HW'(TEAM_DEPTH - 1)) ? '0 : meta_head + HW'(1);
  assign tail_sum   = (HW+1)'(meta_head) + (HW+1)'(meta_count);
  assign tail       = HW'((tail_sum >= (HW+1)'(TEAM_DEPTH))
                          ? tail_sum - (HW+1)'(TEAM_DEPTH) : tail_sum);

  assign meta_raddr = team_src;
  assign meta_we    = (cmd.sweep && (32'(sweep_idx) < NUM_TEAMS)) || cmd.enq_put
                      || cmd.deq_take;
  assign meta_waddr = cmd.sweep ? TW'(sweep_idx) : team_r;
  always_comb begin
    meta_wdata = '0;
    if (cmd.enq_put) begin
      meta_wdata = {meta_head, meta_count + CW'(1)};
    end else if (cmd.deq_take) begin
      meta_wdata = {head_inc, meta_count - CW'(1)};
    end
  end

  gftq_ram #(.WIDTH(HW + CW), .DEPTH(NUM_TEAMS)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_q)
  );

  // Team store
  assign store_we    = cmd.enq_put;
  assign store_waddr = base_r + SA'(tail);
  assign store_raddr = base_r + SA'(meta_head);

  gftq_ram #(.WIDTH(ELEMENT_W), .DEPTH(SD)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (item_el),
    .raddr (store_raddr),
    .rdata (store_q)
  );

  // Active ring
  assign ring_full = (active_count >= AW'(NUM_TEAMS));
  assign ring_we   = cmd.enq_put && team_empty;

  gftq_ram #(.WIDTH(TW), .DEPTH(NUM_TEAMS)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (active_tail),
    .wdata (team_r),
    .raddr (active_head),
    .rdata (ring_q)
  );

  always_ff @(posedge clk) begin
    if (rst || (cmd.sweep && !cmd.sweep_init)) begin
      active_head  <= '0;
      active_tail  <= '0;
      active_count <= '0;
    end else if (ring_we) begin
      active_tail  <= (active_tail == TW'(NUM_TEAMS - 1)) ? '0 : active_tail + TW'(1);
      active_count <= active_count + AW'(1);
    end else if (cmd.deq_take && (meta_count == CW'(1))) begin
      active_head  <= (active_head == TW'(NUM_TEAMS - 1)) ? '0 : active_head + TW'(1);
      active_count <= active_count - AW'(1);
    end
  end

  // Status to the controller
  always_comb begin
    stat            = '0;
    stat.sweep_last = sweep_last;
    stat.map_bad    = (32'(item_el) >= ELEMENT_IDS) || (32'(item_team) >= NUM_TEAMS);
    stat.unmapped   = !mem_q[TW] || (32'(item_el) >= ELEMENT_IDS);
    stat.enq_full   = (meta_count >= CW'(TEAM_DEPTH)) || (team_empty && ring_full);
    stat.ring_empty = (active_count == '0);
    stat.team_empty = team_empty;
    stat.out_free   = !out_valid || out_ready;
  end

  // Result register with a hold slot
  assign res_el = cmd.res_take ? store_q : '0;

  always_ff @(posedge clk) begin
    if (cmd.finish && !stat.out_free) begin
      pend_el <= res_el;
      pend_st <= cmd.res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && stat.out_free) begin
      out_element <= res_el;
      out_status  <= cmd.res_status;
    end else if (cmd.flush) begin
      out_element <= pend_el;
      out_status  <= pend_st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.finish && stat.out_free) || cmd.flush) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Each team holds at most one ring slot
  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    active_count <= AW'(NUM_TEAMS))
    else $error("active ring count out of range");

  // An empty ring has its pointers together
  a_ring_ptrs: assert property (@(posedge clk) disable iff (rst)
    (active_count == '0) |-> (active_head == active_tail))
    else $error("active ring pointers apart while empty");

  // No enqueue commit into a full team
  a_enq_room: assert property (@(posedge clk) disable iff (rst)
    cmd.enq_put |-> !stat.enq_full)
    else $error("enqueue committed into a full team");

endmodule

`default_nettype wire

### rtl/core/grouped_fifo_team_queue_top.sv
// Top level of the team queue: controller, datapath and channel wiring.
//
//   channel      dir   handshake      payload
//   item_in      in    valid/ready    action[1:0], element[9:0], team[3:0]
//   result_out   out   valid/ready    out_element[9:0], status[1:0]
//
// One item at a time. Enqueue reads the member table, then the team metadata;
// dequeue reads the active ring, the team metadata, then the team store.
// Clear zeroes one metadata entry per cycle.
// After reset a clearing pass wipes the member table and the team metadata;
// item_in.ready stays low until it ends.
// A result that finds result_out stalled waits in a hold slot; the next item
// is taken once that result has moved into the output register.
`default_nettype none

module grouped_fifo_team_queue_top #(
  parameter int NUM_TEAMS   = gftq_pkg::NUM_TEAMS_DEF,
  parameter int TEAM_DEPTH  = gftq_pkg::TEAM_DEPTH_DEF,
  parameter int ELEMENT_IDS = gftq_pkg::ELEMENT_IDS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  gftq_item_if.sink   item_in,
  gftq_result_if.source result_out
);
  import gftq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gftq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_in.valid),
    .in_action (action_t'(item_in.action)),
    .in_ready  (item_in.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gftq_dpath #(
    .NUM_TEAMS   (NUM_TEAMS),
    .TEAM_DEPTH  (TEAM_DEPTH),
    .ELEMENT_IDS (ELEMENT_IDS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .in_element  (item_in.element),
    .in_team     (item_in.team),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .out_element (result_out.out_element),
    .out_status  (result_out.status)
  );

endmodule

`default_nettype wire

### sim/grouped_fifo_team_queue_checker.sv
// Checker for the team queue: predicts each result item and compares the block's answers.
`timescale 1ns / 100ps

module grouped_fifo_team_queue_checker (
  input  logic   clk,
  input  logic   rst,
  gftq_item_if   item_mon,
  gftq_result_if result_mon,
  output int     failures,
  output int     answers_due
);
  import gftq_pkg::*;

  localparam int NT = NUM_TEAMS_DEF;
  localparam int TD = TEAM_DEPTH_DEF;
  localparam int NE = ELEMENT_IDS_DEF;

  typedef struct packed {
    logic [ELEMENT_W-1:0] element;
    status_t              status;
  } team_answer_t;

  // Shadow of the block's state
  logic                 member_ok   [NE];
  logic [TEAM_W-1:0]    member_team [NE];
  logic [ELEMENT_W-1:0] team_slot   [NT][TD];
  int                   team_rd     [NT];
  int                   team_wr     [NT];
  int                   team_fill   [NT];
  int                   ring_team   [NT];
  int                   ring_rd;
  int                   ring_wr;
  int                   ring_fill;

  team_answer_t pending_answers[$];
  int           fail_count = 0;

  assign failures = fail_count;

  function automatic int wrap_inc(input int p, input int size);
    return (p + 1 >= size) ? 0 : p + 1;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic empty_all_teams();
    for (int t = 0; t < NT; t++) begin
      team_rd[t]   = 0;
      team_wr[t]   = 0;
      team_fill[t] = 0;
    end
    ring_rd   = 0;
    ring_wr   = 0;
    ring_fill = 0;
  endtask

  // Work out the answer for one item and advance the shadow state
  task automatic predict_team_queue(input action_t act, input logic [ELEMENT_W-1:0] el,
                                    input logic [TEAM_W-1:0] tm, output team_answer_t ans);
    int t;
    ans.element = '0;
    ans.status  = STS_OK;
    case (act)
      ACT_MAP: begin
        if (el >= NE || tm >= NT) begin
          ans.status = STS_UNMAPPED;
        end else begin
          member_ok[el]   = 1'b1;
          member_team[el] = tm;
        end
      end
      ACT_ENQ: begin
        if (el >= NE || !member_ok[el]) begin
          ans.status = STS_UNMAPPED;
        end else begin
          t = int'(member_team[el]);
          if (t >= NT) begin
            ans.status = STS_UNMAPPED;
          end else if (team_fill[t] >= TD) begin
            ans.status = STS_FULL;
          end else if (team_fill[t] == 0 && ring_fill >= NT) begin
            ans.status = STS_FULL;
          end else begin
            // a team with nothing queued goes to the back of the ring
            if (team_fill[t] == 0) begin
              ring_team[ring_wr] = t;
              ring_wr = wrap_inc(ring_wr, NT);
              ring_fill++;
            end
            team_slot[t][team_wr[t]] = el;
            team_wr[t] = wrap_inc(team_wr[t], TD);
            team_fill[t]++;
          end
        end
      end
      ACT_DEQ: begin
        if (ring_fill == 0) begin
          ans.status = STS_EMPTY;
        end else begin
          t = ring_team[ring_rd];
          if (t >= NT || team_fill[t] == 0) begin
            ans.status = STS_EMPTY;
          end else begin
            ans.element = team_slot[t][team_rd[t]];
            team_rd[t] = wrap_inc(team_rd[t], TD);
            team_fill[t]--;
            // front team leaves the ring once drained
            if (team_fill[t] == 0) begin
              ring_rd = wrap_inc(ring_rd, NT);
              ring_fill--;
            end
          end
        end
      end
      default: empty_all_teams();
    endcase
  endtask

  // Predict on each accepted item, compare on each accepted result
  always @(posedge clk) begin
    team_answer_t ans;
    team_answer_t want;
    if (rst) begin
      for (int e = 0; e < NE; e++) begin
        member_ok[e]   = 1'b0;
        member_team[e] = '0;
      end
      empty_all_teams();
      pending_answers.delete();
    end else begin
      if (item_mon.valid && item_mon.ready) begin
        predict_team_queue(action_t'(item_mon.action), item_mon.element, item_mon.team, ans);
        pending_answers.push_back(ans);
      end
      if (result_mon.valid && result_mon.ready) begin
        if (pending_answers.size() == 0) begin
          report_mismatch($sformatf("unexpected result element=%0d status=%0d",
                                    result_mon.out_element, result_mon.status));
        end else begin
          want = pending_answers.pop_front();
          if (result_mon.out_element !== want.element)
            report_mismatch($sformatf("out_element got %0d want %0d",
                                      result_mon.out_element, want.element));
          if (result_mon.status !== want.status)
            report_mismatch($sformatf("status code got %0d want %0d",
                                      result_mon.status, want.status));
        end
      end
    end
    answers_due = pending_answers.size();
  end

endmodule

### sim/grouped_fifo_team_queue_top_test.sv
// Testbench top for the team queue: clock, reset, item stimulus, result stalls and verdict.
`timescale 1ns / 100ps

module grouped_fifo_team_queue_top_test;
  import gftq_pkg::*;

  logic clk;
  logic rst;
  int   failures;
  int   answers_due;
  int   gap_pct   = 0;
  int   stall_pct = 0;

  gftq_item_if   item_ch ();
  gftq_result_if result_ch ();

  grouped_fifo_team_queue_top dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_ch),
    .result_out (result_ch)
  );

  grouped_fifo_team_queue_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .item_mon    (item_ch),
    .result_mon  (result_ch),
    .failures    (failures),
    .answers_due (answers_due)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  // Result side: random stalls at the current rate
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(input action_t act, input logic [ELEMENT_W-1:0] el,
                           input logic [TEAM_W-1:0] tm);
    while ($urandom_range(0, 99) < gap_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.action  <= act;
    item_ch.element <= el;
    item_ch.team    <= tm;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // Hold off new items until every answer has come back
  task automatic drain_answers();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (answers_due != 0);
  endtask

  initial begin
    int                   n;
    int                   pick;
    bit                   grow;
    logic [ELEMENT_W-1:0] el;
    logic [TEAM_W-1:0]    tm;
    logic [ELEMENT_W-1:0] pool [12];
    int                   gap_of   [4];
    int                   stall_of [4];

    gap_of   = '{0, 77, 0, 24};
    stall_of = '{0, 0, 77, 24};

    rst             <= 1'b1;
    item_ch.valid   <= 1'b0;
    item_ch.action  <= ACT_MAP;
    item_ch.element <= '0;
    item_ch.team    <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty, unmapped, ordering by team, duplicates, remap, clear
    send_item(ACT_DEQ, 10'd0, 4'd0);
    send_item(ACT_ENQ, 10'd0, 4'd0);
    send_item(ACT_ENQ, 10'd1023, 4'd15);
    send_item(ACT_MAP, 10'd0, 4'd0);
    send_item(ACT_MAP, 10'd1023, 4'd15);
    send_item(ACT_MAP, 10'h2aa, 4'd5);
    send_item(ACT_MAP, 10'h155, 4'd10);
    send_item(ACT_ENQ, 10'd0, 4'd0);
    send_item(ACT_ENQ, 10'd1023, 4'd0);
    send_item(ACT_ENQ, 10'h155, 4'd0);
    send_item(ACT_ENQ, 10'd0, 4'd0);
    send_item(ACT_MAP, 10'd0, 4'd10);
    send_item(ACT_ENQ, 10'd0, 4'd0);
    send_item(ACT_DEQ, 10'd0, 4'd0);
    send_item(ACT_DEQ, 10'd0, 4'd0);
    send_item(ACT_DEQ, 10'd0, 4'd0);
    send_item(ACT_CLEAR, 10'd0, 4'd0);
    send_item(ACT_DEQ, 10'd0, 4'd0);
    send_item(ACT_ENQ, 10'h2aa, 4'd0);
    send_item(ACT_ENQ, 10'h3ff, 4'd0);
    send_item(ACT_DEQ, 10'd0, 4'd0);
    send_item(ACT_DEQ, 10'd0, 4'd0);

    // Random phases with different idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      drain_answers();
      gap_pct   = gap_of[ph];
      stall_pct = stall_of[ph];
      n = 0;
      // small pool of ids on few teams so teams fill and drain
      foreach (pool[k]) begin
        pool[k] = ELEMENT_W'($urandom_range(0, 1023));
        tm = TEAM_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 3)
                                                 : $urandom_range(0, 15));
        send_item(ACT_MAP, pool[k], tm);
        n++;
      end
      while (n < 275) begin
        // quiet stretch at the start of every 64 items
        gap_pct   = (n % 64 < 12) ? 0 : gap_of[ph];
        stall_pct = (n % 64 < 12) ? 0 : stall_of[ph];
        grow = ((n / 60) % 2) == 0;
        pick = $urandom_range(0, 99);
        el   = pool[$urandom_range(0, 11)];
        tm   = TEAM_W'($urandom_range(0, 15));
        if (pick < 1) begin
          // burst on one team, overflows it
          for (int b = 0; b < 18; b++) send_item(ACT_ENQ, el, tm);
          n += 18;
        end else if (pick < 8) begin
          if ($urandom_range(0, 9) < 3) el = ELEMENT_W'($urandom_range(0, 1023));
          if ($urandom_range(0, 4) != 0) tm = TEAM_W'($urandom_range(0, 3));
          send_item(ACT_MAP, el, tm);
          n++;
        end else if (pick < 12) begin
          send_item(ACT_ENQ, ELEMENT_W'($urandom_range(0, 1023)), tm);
          n++;
        end else if (pick < 14) begin
          send_item(ACT_CLEAR, ELEMENT_W'($urandom_range(0, 1023)), tm);
          n++;
        end else if (pick < (grow ? 74 : 39)) begin
          send_item(ACT_ENQ, el, tm);
          n++;
        end else begin
          send_item(ACT_DEQ, ELEMENT_W'($urandom_range(0, 1023)), tm);
          n++;
        end
      end
    end

    // Wait out the last answers and the longest operation
    drain_answers();
    repeat (24) @(posedge clk);
    if (failures == 0 && answers_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
